@@ rtl/fct_pkg.sv @@
package fct_pkg;

    // block geometry
    localparam int PLANE_COUNT = 6;
    localparam int COORD_WIDTH = 24;
    localparam int AXES        = 3;

    // plane register packing
    localparam int REG_COUNT   = 6;
    localparam int PLANE_W     = 64;
    localparam int NORM_W      = 13;
    localparam int DIST_W      = 25;
    localparam int DIST_LSB    = AXES * NORM_W;
    localparam int RADIUS_W    = 23;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = $clog2(REG_COUNT);

    // distance and radius are scaled by 2^11 to line up with the products
    localparam int ALIGN_SHIFT = 11;

    // datapath widths
    localparam int PROD_W = NORM_W + COORD_WIDTH;
    localparam int BIAS_W = ((DIST_W > RADIUS_W + 1) ? DIST_W : RADIUS_W + 1) + 1;
    localparam int SUM_W  = ((PROD_W > BIAS_W + ALIGN_SHIFT) ? PROD_W
                                                             : BIAS_W + ALIGN_SHIFT) + 2;

    typedef logic [PLANE_W-1:0]             plane_word_t;
    typedef logic signed [COORD_WIDTH-1:0]  coord_t;
    typedef logic signed [NORM_W-1:0]       norm_t;
    typedef logic signed [DIST_W-1:0]       dist_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [BIAS_W-1:0]       bias_t;
    typedef logic signed [SUM_W-1:0]        sum_t;

    // test kinds; the unused code is decoded as a box
    typedef enum logic [CMD_W-1:0] {
        CMD_POINT  = 2'd0,
        CMD_SPHERE = 2'd1,
        CMD_BOX    = 2'd2
    } cmd_t;

    // stage load enables shared by all plane lanes
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } pipe_ctrl_t;

endpackage

@@ rtl/frustum_cull_test_top.sv @@
// Six-plane frustum culling test. Each item (point, sphere or axis-aligned box)
// is checked against the plane registers and gives one item on the m_ channel:
// m_inside_res is 1 when the primitive is inside or touching the frustum. One
// item enters per clock while the pipeline is not stalled; the accepting edge
// loads the per-plane multiply stage, then the partial sums, the final add and
// sign, and the output register are loaded in that order. Each stage holds on
// its own when the next one is full, so bubbles close up under back-pressure.
// Plane registers are written through the cfg_ port (cfg_ready is always high)
// and must only be changed while no item is in flight.
module frustum_cull_test_top
    import fct_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PLANE_W-1:0]   cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CMD_W-1:0]     s_cmd,
    input  coord_t               s_ax,
    input  coord_t               s_ay,
    input  coord_t               s_az,
    input  coord_t               s_bx,
    input  coord_t               s_by,
    input  coord_t               s_bz,
    input  logic [RADIUS_W-1:0]  s_radius,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_inside_res
);

    plane_word_t            planes [PLANE_COUNT];
    coord_t                 a_pt   [AXES];
    coord_t                 b_pt   [AXES];
    logic [PLANE_COUNT-1:0] neg_flags;

    pipe_ctrl_t ctrl;
    logic       en_out;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic m_valid_reg, m_valid_next;
    logic inside_reg, inside_next;

    // plane registers
    assign cfg_ready = 1'b1;

    fct_plane_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .planes   (planes)
    );

    // per-stage enables: a stage loads when empty or when its successor moves
    always_comb begin
        en_out   = !m_valid_reg || m_ready;
        ctrl.en3 = !v3_reg || en_out;
        ctrl.en2 = !v2_reg || ctrl.en3;
        ctrl.en1 = !v1_reg || ctrl.en2;
    end

    assign s_ready = ctrl.en1;

    assign a_pt[0] = s_ax;
    assign a_pt[1] = s_ay;
    assign a_pt[2] = s_az;
    assign b_pt[0] = s_bx;
    assign b_pt[1] = s_by;
    assign b_pt[2] = s_bz;

    // one lane per plane
    for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_plane
        fct_plane_eval u_eval (
            .aclk   (aclk),
            .ctrl   (ctrl),
            .plane  (planes[i]),
            .cmd    (s_cmd),
            .a_pt   (a_pt),
            .b_pt   (b_pt),
            .radius (s_radius),
            .neg    (neg_flags[i])
        );
    end

    // valid bits travel with the lanes
    always_comb begin
        v1_next      = ctrl.en1 ? s_valid : v1_reg;
        v2_next      = ctrl.en2 ? v1_reg  : v2_reg;
        v3_next      = ctrl.en3 ? v2_reg  : v3_reg;
        m_valid_next = en_out   ? v3_reg  : m_valid_reg;
        inside_next  = en_out   ? !(|neg_flags) : inside_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            v3_reg      <= v3_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        inside_reg <= inside_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = inside_reg;

    // pipeline checks
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!v1_reg && !v2_reg && !v3_reg && !m_valid_reg))
        else $error("pipeline not empty after reset");

    a_fill_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(v1_reg) |-> $past(s_valid && s_ready))
        else $error("stage 1 filled without an accepted item");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && v3_reg && v2_reg && v1_reg) |-> !s_ready)
        else $error("item accepted into a full pipeline");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && en_out) |=> m_valid)
        else $error("last stage item lost on its way to the output");

endmodule

@@ rtl/fct_plane_regs.sv @@
module fct_plane_regs
    import fct_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  plane_word_t          wr_data,
    output plane_word_t          planes [PLANE_COUNT]
);

    plane_word_t planes_reg [PLANE_COUNT];

    // one register per plane, indexes past the plane count are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PLANE_COUNT; i++) begin
                planes_reg[i] <= '0;
            end
        end else if (wr_en) begin
            for (int i = 0; i < PLANE_COUNT; i++) begin
                if ((i < REG_COUNT) && (wr_index == CFG_IDX_W'(i))) begin
                    planes_reg[i] <= wr_data;
                end
            end
        end
    end

    assign planes = planes_reg;

endmodule

@@ rtl/fct_plane_eval.sv @@
module fct_plane_eval
    import fct_pkg::*;
(
    input  logic                aclk,
    input  pipe_ctrl_t          ctrl,
    input  plane_word_t         plane,
    input  logic [CMD_W-1:0]    cmd,
    input  coord_t              a_pt [AXES],
    input  coord_t              b_pt [AXES],
    input  logic [RADIUS_W-1:0] radius,
    output logic                neg
);

    norm_t  n [AXES];
    coord_t p [AXES];
    dist_t  d;
    logic   is_box;
    logic   is_sphere;

    prod_t  prod_next [AXES];
    prod_t  prod_reg  [AXES];
    bias_t  bias_next;
    bias_t  bias_reg;

    sum_t   sum_a_next;
    sum_t   sum_b_next;
    sum_t   sum_a_reg;
    sum_t   sum_b_reg;

    sum_t   total;
    logic   neg_next;
    logic   neg_reg;

    // stage 1: unpack plane, pick the corner, multiply per axis
    always_comb begin
        is_box    = (cmd >= CMD_BOX);
        is_sphere = (cmd == CMD_SPHERE);
        d         = dist_t'(plane[DIST_LSB +: DIST_W]);
        for (int k = 0; k < AXES; k++) begin
            n[k] = norm_t'(plane[k*NORM_W +: NORM_W]);
            // box: max on axes whose normal is zero or more, min otherwise
            p[k] = (is_box && !n[k][NORM_W-1]) ? b_pt[k] : a_pt[k];
            prod_next[k] = prod_t'(n[k]) * prod_t'(p[k]);
        end
        bias_next = bias_t'(d)
                  + (is_sphere ? bias_t'(signed'({1'b0, radius})) : bias_t'(0));
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en1) begin
            prod_reg <= prod_next;
            bias_reg <= bias_next;
        end
    end

    // stage 2: two partial sums, bias aligned to the product fraction
    always_comb begin
        sum_a_next = sum_t'(prod_reg[0]) + sum_t'(prod_reg[1]);
        sum_b_next = sum_t'(prod_reg[2]) + (sum_t'(bias_reg) <<< ALIGN_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en2) begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    // stage 3: final add, keep only the sign
    always_comb begin
        total    = sum_a_reg + sum_b_reg;
        neg_next = total[SUM_W-1];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en3) begin
            neg_reg <= neg_next;
        end
    end

    assign neg = neg_reg;

endmodule

@@ test/frustum_cull_test_top_tb.sv @@
// holds the plane registers as last written and the queue of expected verdicts
class cull_scoreboard;
    fct_pkg::plane_word_t planes [fct_pkg::PLANE_COUNT];
    bit                   verdict_q [$];
    int                   mismatches;
    int                   failures;

    function new();
        foreach (planes[i]) planes[i] = '0;
        mismatches = 0;
        failures   = 0;
    endfunction

    // writes beyond the plane list are dropped, as in the block
    function void write_plane(int idx, fct_pkg::plane_word_t data);
        if (idx < fct_pkg::PLANE_COUNT) planes[idx] = data;
    endfunction

    // exact signed distance of the chosen corner against every plane
    function bit predict_in_view(logic [fct_pkg::CMD_W-1:0] cmd,
                                 fct_pkg::coord_t ax, fct_pkg::coord_t ay,
                                 fct_pkg::coord_t az, fct_pkg::coord_t bx,
                                 fct_pkg::coord_t by, fct_pkg::coord_t bz,
                                 logic [fct_pkg::RADIUS_W-1:0] radius);
        longint pa [3];
        longint pb [3];
        longint nrm [3];
        longint corner;
        longint sdist;
        bit     in_view;
        in_view = 1'b1;
        pa[0] = ax; pa[1] = ay; pa[2] = az;
        pb[0] = bx; pb[1] = by; pb[2] = bz;
        for (int i = 0; i < fct_pkg::PLANE_COUNT; i++) begin
            sdist = fct_pkg::dist_t'(planes[i][fct_pkg::DIST_LSB +: fct_pkg::DIST_W]);
            sdist = sdist * (longint'(1) << fct_pkg::ALIGN_SHIFT);
            for (int k = 0; k < fct_pkg::AXES; k++) begin
                nrm[k] = fct_pkg::norm_t'(planes[i][k*fct_pkg::NORM_W +: fct_pkg::NORM_W]);
                // box corner: max where the normal is zero or more, min otherwise
                if (cmd >= fct_pkg::CMD_BOX) begin
                    corner = (nrm[k] >= 0) ? pb[k] : pa[k];
                end else begin
                    corner = pa[k];
                end
                sdist = sdist + nrm[k] * corner;
            end
            if (cmd == fct_pkg::CMD_SPHERE) begin
                sdist = sdist + longint'(radius) * (longint'(1) << fct_pkg::ALIGN_SHIFT);
            end
            if (sdist < 0) in_view = 1'b0;
        end
        return in_view;
    endfunction

    function void note_item(logic [fct_pkg::CMD_W-1:0] cmd,
                            fct_pkg::coord_t ax, fct_pkg::coord_t ay, fct_pkg::coord_t az,
                            fct_pkg::coord_t bx, fct_pkg::coord_t by, fct_pkg::coord_t bz,
                            logic [fct_pkg::RADIUS_W-1:0] radius);
        verdict_q.push_back(predict_in_view(cmd, ax, ay, az, bx, by, bz, radius));
    endfunction

    function void check_result(logic actual);
        bit expected;
        if (verdict_q.size() == 0) begin
            failures++;
            if (mismatches < 10) $display("unexpected item: inside_res %0b", actual);
            mismatches++;
        end else begin
            expected = verdict_q.pop_front();
            if (actual !== expected) begin
                failures++;
                if (mismatches < 10) begin
                    $display("mismatch: inside_res expected %0b, got %0b", expected, actual);
                end
                mismatches++;
            end
        end
    endfunction

    function int pending();
        return verdict_q.size();
    endfunction
endclass

module frustum_cull_test_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fct_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int COORD_MAX   = 2**(COORD_WIDTH-1) - 1;
    localparam int COORD_MIN   = -(2**(COORD_WIDTH-1));
    localparam int RADIUS_MAX  = 2**RADIUS_W - 1;
    localparam int NORM_MAX    = 2**(NORM_W-1) - 1;
    localparam int NORM_MIN    = -(2**(NORM_W-1));
    localparam int DIST_MAX    = 2**(DIST_W-1) - 1;
    localparam int DIST_MIN    = -(2**(DIST_W-1));
    localparam int UNIT_NORM   = 2**ALIGN_SHIFT;
    localparam int BOX_HALF    = 40960;
    localparam int DRAIN_CYCLES     = 8;
    localparam int HOLD_CYCLES      = 300;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RAND_PHASES      = 12;
    localparam int ITEMS_PER_PHASE  = 108;
    localparam int PRESSURE_PHASE   = 4;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PLANE_W-1:0]   cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_cmd;
    coord_t               s_ax, s_ay, s_az, s_bx, s_by, s_bz;
    logic [RADIUS_W-1:0]  s_radius;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_inside_res;

    cull_scoreboard cull_sb;
    int             idle_cycles = 0;
    bit             hold_req;
    int             send_burst;

    frustum_cull_test_top i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_ax         (s_ax),
        .s_ay         (s_ay),
        .s_az         (s_az),
        .s_bx         (s_bx),
        .s_by         (s_by),
        .s_bz         (s_bz),
        .s_radius     (s_radius),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_inside_res (m_inside_res)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // watch both channels and the config port at every edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) cull_sb.check_result(m_inside_res);
            if (cfg_valid && cfg_ready) cull_sb.write_plane(int'(cfg_index), cfg_data);
            if (s_valid && s_ready) begin
                cull_sb.note_item(s_cmd, s_ax, s_ay, s_az, s_bx, s_by, s_bz, s_radius);
            end
            if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // watchdog on cycles with no item moving anywhere
    initial begin
        wait (aresetn === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("status: fail");
        $finish;
    end

    // result side: random stalls, bursts with none, and one long hold-off
    initial begin
        int gap;
        int burst_left;
        bit hold_done;
        burst_left = 0;
        hold_done  = 1'b0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req && !hold_done) begin
                gap = HOLD_CYCLES;
                hold_done = 1'b1;
            end else if (burst_left > 0) begin
                gap = 0;
                burst_left--;
            end else begin
                gap = $urandom_range(0, 3);
                if ($urandom_range(0, 31) == 0) burst_left = $urandom_range(16, 64);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    function automatic int rand_around(int span);
        return int'($urandom_range(0, 2*span)) - span;
    endfunction

    // mostly near the region of interest, sometimes anywhere in the field
    function automatic coord_t rand_coord(int span);
        if ($urandom_range(0, 3) == 0) return coord_t'($urandom);
        return coord_t'(rand_around(span));
    endfunction

    function automatic plane_word_t pack_plane(int nx, int ny, int nz, int d);
        return {DIST_W'(d), NORM_W'(nz), NORM_W'(ny), NORM_W'(nx)};
    endfunction

    task automatic send_item(logic [CMD_W-1:0] cmd, coord_t ax, coord_t ay, coord_t az,
                             coord_t bx, coord_t by, coord_t bz,
                             logic [RADIUS_W-1:0] radius);
        int gap;
        if (send_burst > 0) begin
            gap = 0;
            send_burst--;
        end else begin
            gap = $urandom_range(0, 3);
            if ($urandom_range(0, 31) == 0) send_burst = $urandom_range(16, 64);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_cmd    <= cmd;
        s_ax     <= ax;
        s_ay     <= ay;
        s_az     <= az;
        s_bx     <= bx;
        s_by     <= by;
        s_bz     <= bz;
        s_radius <= radius;
        do @(posedge aclk); while (!s_ready);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(int idx, plane_word_t data);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic write_all_planes(plane_word_t w);
        for (int i = 0; i < REG_COUNT; i++) write_reg(i, w);
        cfg_valid <= 1'b0;
    endtask

    // axis-aligned box of half extents r, normals tilted by up to jitter
    task automatic load_box_frustum(int r0, int r1, int r2, int jitter);
        int nrm [3];
        int half [3];
        half[0] = r0; half[1] = r1; half[2] = r2;
        for (int k = 0; k < AXES; k++) begin
            for (int side = 0; side < 2; side++) begin
                for (int j = 0; j < AXES; j++) nrm[j] = rand_around(jitter);
                nrm[k] = (side == 0) ? UNIT_NORM : -UNIT_NORM;
                write_reg(2*k + side, pack_plane(nrm[0], nrm[1], nrm[2], half[k]));
            end
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_item(int span);
        logic [CMD_W-1:0]    cmd;
        coord_t              a [3];
        coord_t              b [3];
        int                  top;
        logic [RADIUS_W-1:0] rad;
        cmd = ($urandom_range(0, 19) == 0) ? CMD_SPARE
                                           : CMD_W'($urandom_range(CMD_POINT, CMD_BOX));
        for (int k = 0; k < AXES; k++) begin
            a[k] = rand_coord(span);
            if ($urandom_range(0, 9) == 0) begin
                // unordered or arbitrary box corners
                b[k] = rand_coord(span);
            end else begin
                top  = int'(a[k]) + int'($urandom_range(0, span));
                b[k] = coord_t'((top > COORD_MAX) ? COORD_MAX : top);
            end
        end
        rad = ($urandom_range(0, 3) == 0) ? RADIUS_W'($urandom)
                                          : RADIUS_W'($urandom_range(0, span));
        send_item(cmd, a[0], a[1], a[2], b[0], b[1], b[2], rad);
    endtask

    // wait for the queue to empty, then for the pipeline to settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (cull_sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // main sequence
    initial begin
        int          mode;
        int          span;
        int          half [3];
        plane_word_t w;
        cull_sb     = new();
        hold_req    = 1'b0;
        send_burst  = 0;
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_cmd       = CMD_POINT;
        s_ax = '0; s_ay = '0; s_az = '0;
        s_bx = '0; s_by = '0; s_bz = '0;
        s_radius    = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // planes at reset are all zero: everything is in view
        send_item(CMD_POINT, COORD_MAX, COORD_MAX, COORD_MAX,
                  coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), RADIUS_MAX);
        send_item(CMD_SPHERE, COORD_MIN, COORD_MIN, COORD_MIN,
                  coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), '0);
        send_item(CMD_SPARE, COORD_MAX, COORD_MIN, 0, COORD_MIN, COORD_MAX, 0,
                  RADIUS_W'($urandom));
        wait_idle();

        // exact box frustum: boundaries, touching spheres, boxes
        load_box_frustum(BOX_HALF, BOX_HALF, BOX_HALF, 0);
        send_item(CMD_POINT, 0, 0, 0, coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), RADIUS_W'($urandom));
        send_item(CMD_POINT, -BOX_HALF, 0, 0, 0, 0, 0, RADIUS_W'($urandom));
        send_item(CMD_POINT, -BOX_HALF - 1, 0, 0, 0, 0, 0, RADIUS_W'($urandom));
        send_item(CMD_POINT, BOX_HALF, BOX_HALF, BOX_HALF, 0, 0, 0, 0);
        send_item(CMD_POINT, 0, 0, BOX_HALF + 1, 0, 0, 0, 0);
        send_item(CMD_SPHERE, -BOX_HALF - 100, 0, 0, coord_t'($urandom), 0, 0, 100);
        send_item(CMD_SPHERE, -BOX_HALF - 101, 0, 0, 0, coord_t'($urandom), 0, 100);
        send_item(CMD_SPHERE, COORD_MIN, 0, 0, 0, 0, 0, RADIUS_MAX);
        send_item(CMD_BOX, -BOX_HALF - 5, -5, -5, -BOX_HALF - 1, 5, 5, RADIUS_W'($urandom));
        send_item(CMD_BOX, -2*BOX_HALF, -2*BOX_HALF, -2*BOX_HALF,
                  2*BOX_HALF, 2*BOX_HALF, 2*BOX_HALF, 0);
        // box given with min above max
        send_item(CMD_BOX, BOX_HALF, BOX_HALF, BOX_HALF, -BOX_HALF, -BOX_HALF, -BOX_HALF, 0);
        send_item(CMD_SPARE, BOX_HALF + 1, 0, 0, BOX_HALF + 9, 3, 3, RADIUS_MAX);
        wait_idle();

        // extreme plane words
        for (int e = 0; e < 3; e++) begin
            case (e)
                0:       w = '1;
                1:       w = pack_plane(NORM_MAX, NORM_MAX, NORM_MAX, DIST_MAX);
                default: w = pack_plane(NORM_MIN, NORM_MIN, NORM_MIN, DIST_MIN);
            endcase
            write_all_planes(w);
            send_item(CMD_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 0);
            send_item(CMD_SPHERE, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, RADIUS_MAX);
            send_item(CMD_BOX, COORD_MIN, COORD_MIN, COORD_MIN,
                      COORD_MAX, COORD_MAX, COORD_MAX, 0);
            wait_idle();
        end

        // random phases, each with a fresh set of planes
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            mode = ph % 3;
            span = 2**21;
            if (mode == 0) begin
                for (int k = 0; k < AXES; k++) half[k] = $urandom_range(2**12, 2**21);
                span = 2 * ((half[0] > half[1]) ? ((half[0] > half[2]) ? half[0] : half[2])
                                                : ((half[1] > half[2]) ? half[1] : half[2]));
                load_box_frustum(half[0], half[1], half[2], 256);
            end else begin
                for (int i = 0; i < REG_COUNT; i++) begin
                    if (mode == 1) begin
                        w = {$urandom, $urandom};
                    end else begin
                        case ($urandom_range(0, 4))
                            0:       w = '0;
                            1:       w = '1;
                            2:       w = pack_plane(NORM_MAX, NORM_MAX, NORM_MAX, DIST_MAX);
                            3:       w = pack_plane(NORM_MIN, NORM_MIN, NORM_MIN, DIST_MIN);
                            default: w = {$urandom, $urandom};
                        endcase
                    end
                    write_reg(i, w);
                end
                cfg_valid <= 1'b0;
            end
            // indexes past the plane list must leave the planes alone
            if ($urandom_range(0, 1) == 1) begin
                for (int idx = REG_COUNT; idx < 2**CFG_IDX_W; idx++) begin
                    write_reg(idx, {$urandom, $urandom});
                end
                cfg_valid <= 1'b0;
            end
            if (ph == PRESSURE_PHASE) hold_req = 1'b1;
            repeat (ITEMS_PER_PHASE) send_random_item(span);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (cull_sb.failures == 0 && cull_sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/fct_pkg.sv
rtl/fct_plane_regs.sv
rtl/fct_plane_eval.sv
rtl/frustum_cull_test_top.sv
test/frustum_cull_test_top_tb.sv
